@@ hw/rtl/cst_pkg.sv @@
// Shared types and codes for the compacting slot table.
// Used by cst_shift and compacting_slot_table; no dependencies.
`timescale 1ns / 1ps

package cst_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] status_t;

    localparam cmd_t CMD_ACTIVATE = 2'd0;
    localparam cmd_t CMD_DELETE   = 2'd1;
    localparam cmd_t CMD_READ     = 2'd2;
    localparam cmd_t CMD_COUNT    = 2'd3;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_FULL        = 3'd1;
    localparam status_t ST_NO_MATERIAL = 3'd2;
    localparam status_t ST_NOT_PACKED  = 3'd3;
    localparam status_t ST_RANGE       = 3'd4;
    localparam status_t ST_EMPTY       = 3'd5;

    localparam int MAT_W = 16;

    // Request from the command sequencer to the shift engine.
    typedef struct packed {
        logic go;
    } shf_req_t;

    // Shift engine status and its claim on the slot memory.
    typedef struct packed {
        logic busy;
        logic rd_en;
        logic wr_en;
    } shf_stat_t;

endpackage

@@ hw/rtl/cst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/cst_shift.sv @@
// Shift engine: moves slot entries down by one, one entry per read/write pair.
// Depends on cst_pkg; drives one port pair of cst_ram through the top level.
`timescale 1ns / 1ps

module cst_shift #(
    parameter int AW = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cst_pkg::shf_req_t     req,
    input  logic [AW-1:0]         first,
    input  logic [AW-1:0]         last,
    input  logic [cst_pkg::MAT_W-1:0] rd_data,
    output cst_pkg::shf_stat_t    stat,
    output logic [AW-1:0]         rd_addr,
    output logic [AW-1:0]         wr_addr,
    output logic [cst_pkg::MAT_W-1:0] wr_data
);

    import cst_pkg::*;

    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] ptr_inc;

    assign ptr_inc = ptr_reg + AW'(1);

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        last_next  = last_reg;
        if (!busy_reg) begin
            if (req.go) begin
                ptr_next   = first;
                last_next  = last;
                phase_next = 1'b0;
                busy_next  = (first != last);
            end
        end else if (!phase_reg) begin
            phase_next = 1'b1;
        end else begin
            // write done: advance, stop once the last entry has moved down
            ptr_next   = ptr_inc;
            phase_next = 1'b0;
            if (ptr_inc == last_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
        ptr_reg  <= ptr_next;
        last_reg <= last_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.rd_en = busy_reg & ~phase_reg;
    assign stat.wr_en = busy_reg & phase_reg;
    assign rd_addr    = ptr_inc;
    assign wr_addr    = ptr_reg;
    assign wr_data    = rd_data;

endmodule

@@ hw/rtl/compacting_slot_table.sv @@
// Compacting slot table: a packed table of material handles with activate,
// delete, read and count commands. Depends on cst_pkg, cst_ram, cst_shift.
//
// Usage:
//   The s_ channel takes one command word per valid/ready handshake; the
//   m_ channel returns exactly one result word for each command.
//   The block handles one word at a time: s_ready is high only while it is
//   idle, and it stays low from acceptance until the result word is taken.
// Result path (from the accept edge to m_valid):
//   activate, count, rejected commands, read of an empty slot: the result
//   is registered straight into S_OUT. Read of an occupied slot passes
//   through S_READ (registered memory read) first. Delete of slot idx waits
//   in S_SHIFT while the shift engine moves the entries above idx down; the
//   shift engine moves one entry per read/write pair over the single
//   memory port pair.
// Stall: while m_ready is low the result word is held and no command is taken.
// Reset: aresetn (synchronous, active low) empties the table and clears the
//   wireframe flag at once; no clearing pass is needed.
`timescale 1ns / 1ps

module compacting_slot_table #(
    parameter int SLOT_COUNT = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cst_pkg::cmd_t    s_command,
    input  logic [15:0]      s_material_id,
    input  logic             s_material_present,
    input  logic             s_material_packed,
    input  logic [3:0]       s_slot_index,
    output logic             m_valid,
    input  logic             m_ready,
    output cst_pkg::status_t m_status,
    output logic [2:0]       m_slot_out,
    output logic [15:0]      m_material_out,
    output logic             m_occupied,
    output logic [3:0]       m_used_count,
    output logic             m_wireframe
);

    import cst_pkg::*;

    localparam int AW   = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    used_reg, used_next;
    logic             wf_reg, wf_next;
    status_t          status_reg, status_next;
    logic [2:0]       slot_reg, slot_next;
    logic [MAT_W-1:0] mat_reg, mat_next;
    logic             occ_reg, occ_next;

    logic             accept;
    logic             full;
    logic             idx_bad;
    logic             idx_used;
    logic [AW-1:0]    idx_addr;

    logic             top_we, top_re;
    shf_req_t         shf_req;
    shf_stat_t        shf_stat;
    logic [AW-1:0]    shf_rd_addr, shf_wr_addr;
    logic [MAT_W-1:0] shf_wr_data;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [MAT_W-1:0] ram_wdata, ram_rdata;

    assign accept   = s_valid & s_ready;
    assign full     = (used_reg == CW'(SLOT_COUNT));
    assign idx_bad  = (CMPW'(s_slot_index) >= CMPW'(SLOT_COUNT));
    assign idx_used = (CMPW'(s_slot_index) < CMPW'(used_reg));
    assign idx_addr = AW'(s_slot_index);

    always_comb begin
        state_next  = state_reg;
        used_next   = used_reg;
        wf_next     = wf_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        mat_next    = mat_reg;
        occ_next    = occ_reg;
        top_we      = 1'b0;
        top_re      = 1'b0;
        shf_req.go  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    slot_next   = 3'd0;
                    mat_next    = '0;
                    occ_next    = 1'b0;
                    state_next  = S_OUT;
                    case (s_command)
                        CMD_ACTIVATE: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else if (!s_material_present) begin
                                status_next = ST_NO_MATERIAL;
                            end else if (!s_material_packed) begin
                                status_next = ST_NOT_PACKED;
                            end else begin
                                top_we    = 1'b1;
                                slot_next = 3'(used_reg);
                                mat_next  = s_material_id;
                                occ_next  = 1'b1;
                                used_next = used_reg + CW'(1);
                                if (used_reg == '0) begin
                                    wf_next = 1'b0;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (idx_bad) begin
                                status_next = ST_RANGE;
                            end else begin
                                slot_next = 3'(s_slot_index);
                                if (!idx_used) begin
                                    status_next = ST_EMPTY;
                                end else begin
                                    // deleting slot 0 as the last entry sets wireframe
                                    if (s_slot_index == 4'd0 && used_reg <= CW'(1)) begin
                                        wf_next = 1'b1;
                                    end
                                    used_next  = used_reg - CW'(1);
                                    shf_req.go = 1'b1;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (idx_bad) begin
                                status_next = ST_RANGE;
                            end else begin
                                slot_next = 3'(s_slot_index);
                                if (idx_used) begin
                                    top_re     = 1'b1;
                                    occ_next   = 1'b1;
                                    state_next = S_READ;
                                end
                            end
                        end
                        default: begin
                            // count: result carries only the used count
                        end
                    endcase
                end
            end
            S_READ: begin
                mat_next   = ram_rdata;
                state_next = S_OUT;
            end
            S_SHIFT: begin
                if (!shf_stat.busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            wf_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            wf_reg    <= wf_next;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        mat_reg    <= mat_next;
        occ_reg    <= occ_next;
    end

    // hand the memory to the shift engine while it runs
    assign ram_we    = shf_stat.busy ? shf_stat.wr_en : top_we;
    assign ram_waddr = shf_stat.busy ? shf_wr_addr : AW'(used_reg);
    assign ram_wdata = shf_stat.busy ? shf_wr_data : s_material_id;
    assign ram_re    = shf_stat.busy ? shf_stat.rd_en : top_re;
    assign ram_raddr = shf_stat.busy ? shf_rd_addr : idx_addr;

    cst_shift #(
        .AW(AW)
    ) u_shift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (shf_req),
        .first   (idx_addr),
        .last    (AW'(used_reg - CW'(1))),
        .rd_data (ram_rdata),
        .stat    (shf_stat),
        .rd_addr (shf_rd_addr),
        .wr_addr (shf_wr_addr),
        .wr_data (shf_wr_data)
    );

    cst_ram #(
        .WIDTH(MAT_W),
        .DEPTH(SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_status       = status_reg;
    assign m_slot_out     = slot_reg;
    assign m_material_out = mat_reg;
    assign m_occupied     = occ_reg;
    assign m_used_count   = 4'(used_reg);
    assign m_wireframe    = wf_reg;

endmodule
